[rtl/core/ic3_pkg.sv]
// Shared constants, types and register codes for the 3x3 convolution core.
package ic3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int PIXEL_BITS  = 8;
  localparam int COEF_BITS   = 8;
  localparam int TAPS        = 3;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = COL_BITS + 1;
  localparam int ROW_BITS    = 12;
  localparam int RESULT_BITS = 20;
  localparam int KROW_BITS   = TAPS * COEF_BITS;
  localparam int CFG_BITS    = 24;
  localparam int CFG_IDX_BITS = 3;
  localparam int PROD_BITS   = PIXEL_BITS + COEF_BITS + 1;
  localparam int ROWSUM_BITS = PROD_BITS + 2;
  localparam int TOTAL_BITS  = PROD_BITS + 4;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = WIDTH_BITS'(640);
  localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = ROW_BITS'(480);
  localparam logic [KROW_BITS-1:0]  KTOP_RESET   = KROW_BITS'(0);
  localparam logic [KROW_BITS-1:0]  KMID_RESET   = KROW_BITS'(256);
  localparam logic [KROW_BITS-1:0]  KBOT_RESET   = KROW_BITS'(0);

  typedef logic [PIXEL_BITS-1:0]         pixel_t;
  typedef logic [COL_BITS-1:0]           col_t;
  typedef logic [WIDTH_BITS-1:0]         width_t;
  typedef logic [ROW_BITS-1:0]           row_t;
  typedef logic [KROW_BITS-1:0]          krow_t;
  typedef logic [CFG_BITS-1:0]           cfg_data_t;
  typedef logic [CFG_IDX_BITS-1:0]       cfg_index_t;
  typedef logic signed [RESULT_BITS-1:0] result_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ROWSUM_BITS-1:0] rowsum_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_KERNEL_TOP   = 3'd2,
    REG_KERNEL_MID   = 3'd3,
    REG_KERNEL_BOT   = 3'd4
  } cfg_reg_t;

endpackage

[rtl/core/image_convolution_3x3_core.sv]
// 3x3 signed-kernel convolution over a raster pixel stream, with line stores.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------
//  in      | input     | in_valid/in_stall | pixel_value, mode
//  out     | output    | out_valid/out_stall | result_value, end_of_frame
//  cfg     | input     | cfg_write_enable  | cfg_index, cfg_data
//
// One beat per clock is accepted while in_stall is low. The result of a neighborhood whose
// last beat is accepted goes through read, window, multiply, row sums and result register.
// The rate is set by the single read and single write port of each line store,
// both used once per beat; a same-entry write/read pair is forwarded.
// Reset clears counters, window and pipeline; line stores have no clearing pass.
// in_stall rises only while the result register is stalled and the last
// pipeline stage is also full.
module image_convolution_3x3_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ic3_pkg::pixel_t      pixel_value,
  input  logic                 mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ic3_pkg::result_t     result_value,
  output logic                 end_of_frame,
  input  logic                 cfg_write_enable,
  input  ic3_pkg::cfg_index_t  cfg_index,
  input  ic3_pkg::cfg_data_t   cfg_data
);
  import ic3_pkg::*;

  // configuration registers
  width_t frame_width;
  row_t   frame_height;
  krow_t  kernel_row [TAPS];

  // stream position counters
  col_t in_col;
  row_t in_row;
  col_t out_col;
  row_t out_row;

  // line stores and forwarding
  pixel_t mem_upper [MAX_WIDTH];
  pixel_t mem_lower [MAX_WIDTH];
  pixel_t rd_up;
  pixel_t rd_lo;
  logic   fwd_valid;
  col_t   fwd_ic;
  pixel_t fwd_up;
  pixel_t fwd_lo;

  // neighborhood window, [row][col]
  pixel_t window [TAPS][TAPS];

  // pipeline stages
  logic    s1_valid, s1_emit, s1_border, s1_last;
  col_t    s1_ic;
  pixel_t  s1_pix;
  logic    s2_valid, s2_border, s2_last;
  logic    s3_valid, s3_border, s3_last;
  pixel_t  s3_center;
  prod_t   prod [TAPS][TAPS];
  logic    s4_valid, s4_border, s4_last;
  pixel_t  s4_center;
  rowsum_t row_sum [TAPS];

  // stage 0 control
  logic                    adv;
  logic                    enter;
  logic                    tail;
  logic                    emit;
  logic                    border;
  logic                    last;
  width_t                  eff_w;
  row_t                    eff_h;
  width_t                  ic_inc;
  width_t                  oc_inc;
  logic [ROW_BITS:0]       orow_inc;
  logic                    in_wrap;
  logic                    out_wrap;
  col_t                    in_col_next;
  row_t                    in_row_next;
  col_t                    out_col_next;
  row_t                    out_row_next;
  pixel_t                  pix;

  // stage 1 and later data
  logic                    fwd_hit;
  pixel_t                  up_val;
  pixel_t                  lo_val;
  coef_t                   coef [TAPS][TAPS];
  prod_t                   prod_next [TAPS][TAPS];
  logic signed [TOTAL_BITS-1:0] total;

  // advance unless the result register is stalled and the last stage is full
  assign adv      = !(out_valid && out_stall && s4_valid);
  assign in_stall = !adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= WIDTH_RESET;
      frame_height  <= HEIGHT_RESET;
      kernel_row[0] <= KTOP_RESET;
      kernel_row[1] <= KMID_RESET;
      kernel_row[2] <= KBOT_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width   <= cfg_data[WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height  <= cfg_data[ROW_BITS-1:0];
        REG_KERNEL_TOP:   kernel_row[0] <= cfg_data[KROW_BITS-1:0];
        REG_KERNEL_MID:   kernel_row[1] <= cfg_data[KROW_BITS-1:0];
        REG_KERNEL_BOT:   kernel_row[2] <= cfg_data[KROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size and position decode
  always_comb begin
    if (frame_width == '0) begin
      eff_w = width_t'(1);
    end else if (frame_width > width_t'(MAX_WIDTH)) begin
      eff_w = width_t'(MAX_WIDTH);
    end else begin
      eff_w = frame_width;
    end
    eff_h = (frame_height == '0) ? row_t'(1) : frame_height;

    tail  = in_row >= eff_h;
    enter = in_valid && !in_stall && (tail || !mode);
    emit  = (in_row >= row_t'(1) && in_col != '0) || in_row >= row_t'(2);
    pix   = tail ? '0 : pixel_value;

    ic_inc  = {1'b0, in_col} + width_t'(1);
    in_wrap = ic_inc >= eff_w;
    in_col_next = in_wrap ? '0 : ic_inc[COL_BITS-1:0];
    in_row_next = (in_wrap && in_row != '1) ? in_row + row_t'(1) : in_row;

    oc_inc   = {1'b0, out_col} + width_t'(1);
    orow_inc = {1'b0, out_row} + (ROW_BITS+1)'(1);
    out_wrap = oc_inc >= eff_w;
    border = out_row == '0 || orow_inc >= {1'b0, eff_h} || out_col == '0 || out_wrap;
    last   = orow_inc >= {1'b0, eff_h} && out_wrap;
    out_col_next = out_wrap ? '0 : oc_inc[COL_BITS-1:0];
    out_row_next = out_wrap ? orow_inc[ROW_BITS-1:0] : out_row;
  end

  // advance counters; the last result of a frame restarts all of them
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (enter) begin
      if (emit && last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        in_col <= in_col_next;
        in_row <= in_row_next;
        if (emit) begin
          out_col <= out_col_next;
          out_row <= out_row_next;
        end
      end
    end
  end

  // stage 1: line store reads and control
  always_ff @(posedge clk) begin
    if (enter) begin
      rd_up <= mem_upper[in_col];
      rd_lo <= mem_lower[in_col];
    end
    if (adv && s1_valid) begin
      mem_upper[s1_ic] <= lo_val;
      mem_lower[s1_ic] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= enter;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ic     <= in_col;
      s1_pix    <= pix;
      s1_emit   <= emit;
      s1_border <= border;
      s1_last   <= last;
    end
  end

  // forward the entry written on the same edge as this beat's read
  assign fwd_hit = fwd_valid && fwd_ic == s1_ic;
  assign up_val  = fwd_hit ? fwd_up : rd_up;
  assign lo_val  = fwd_hit ? fwd_lo : rd_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (adv) begin
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_ic <= s1_ic;
      fwd_up <= lo_val;
      fwd_lo <= s1_pix;
    end
  end

  // shift the window left and load the new column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < TAPS; r++) begin
        for (int c = 0; c < TAPS; c++) begin
          window[r][c] <= '0;
        end
      end
    end else if (adv && s1_valid) begin
      for (int r = 0; r < TAPS; r++) begin
        window[r][0] <= window[r][1];
        window[r][1] <= window[r][2];
      end
      window[0][2] <= up_val;
      window[1][2] <= lo_val;
      window[2][2] <= s1_pix;
    end
  end

  // stage 2..4 valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // nine products of window and kernel
  always_comb begin
    for (int r = 0; r < TAPS; r++) begin
      for (int c = 0; c < TAPS; c++) begin
        coef[r][c] = kernel_row[r][c*COEF_BITS +: COEF_BITS];
        prod_next[r][c] = $signed({1'b0, window[r][c]}) * coef[r][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_border <= s1_border;
      s2_last   <= s1_last;
      s3_border <= s2_border;
      s3_last   <= s2_last;
      s3_center <= window[1][1];
      for (int r = 0; r < TAPS; r++) begin
        for (int c = 0; c < TAPS; c++) begin
          prod[r][c] <= prod_next[r][c];
        end
      end
      s4_border <= s3_border;
      s4_last   <= s3_last;
      s4_center <= s3_center;
      for (int r = 0; r < TAPS; r++) begin
        row_sum[r] <= ROWSUM_BITS'(prod[r][0]) + ROWSUM_BITS'(prod[r][1])
                    + ROWSUM_BITS'(prod[r][2]);
      end
    end
  end

  // final sum and result register
  assign total = TOTAL_BITS'(row_sum[0]) + TOTAL_BITS'(row_sum[1])
               + TOTAL_BITS'(row_sum[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      result_value <= s4_border ? result_t'({1'b0, s4_center})
                                : total[RESULT_BITS-1:0];
      end_of_frame <= s4_last;
    end
  end

  // checks
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (enter && emit && last) |=> (in_col == '0 && in_row == '0 &&
                                 out_col == '0 && out_row == '0))
    else $error("counters not restarted after last result");

  a_last_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && !adv) |=> (s4_valid && $stable(s4_last) && $stable(s4_center)))
    else $error("last stage lost its beat while stalled");

  a_first_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_ic) && $stable(s1_pix)))
    else $error("first stage lost its beat while stalled");

endmodule

[tb/tb_top.sv]
// Testbench for the 3x3 convolution core: predicts every filtered pixel and checks it.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ic3_pkg::*;

  typedef struct packed {
    result_t value;
    logic    eof;
  } result_rec_t;

  // DUT connections
  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  pixel_t     pixel_value;
  logic       mode;
  logic       out_valid;
  logic       out_stall = 1'b0;
  result_t    result_value;
  logic       end_of_frame;
  logic       cfg_write_enable;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  // Predictor state: register shadows, line history, tap window, counters
  width_t width_reg;
  row_t   height_reg;
  krow_t  kernel_rows [TAPS];
  pixel_t line_older [MAX_WIDTH];
  pixel_t line_newer [MAX_WIDTH];
  pixel_t taps [TAPS][TAPS];
  int     feed_col;
  int     feed_row;
  int     emit_col;
  int     emit_row;

  result_rec_t filtered_queue [$];
  int          frames_closed = 0;
  int          items_taken = 0;
  int          mismatch_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;

  image_convolution_3x3_core DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pixel_value      (pixel_value),
    .mode             (mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_value     (result_value),
    .end_of_frame     (end_of_frame),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10ns clk = ~clk;

  // Stall the result channel at the rate of the current phase
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic report_mismatch(string what);
    if (mismatch_count < 50) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // Compare each result beat with the oldest predicted pixel
  always @(posedge clk) begin : check_results
    result_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (filtered_queue.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending", result_value));
      end else begin
        want = filtered_queue.pop_front();
        if (result_value !== want.value) begin
          report_mismatch($sformatf("result_value %0d, expected %0d",
                                    result_value, want.value));
        end
        if (end_of_frame !== want.eof) begin
          report_mismatch($sformatf("end_of_frame %b, expected %b",
                                    end_of_frame, want.eof));
        end
      end
    end
  end

  function automatic int frame_cols();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int frame_rows();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // Advance the predictor by one accepted beat; queue the pixel it releases
  function automatic void convolve_beat(pixel_t px, logic flush);
    int          cols, rows, col, row, ocol, orow, acc, r, c;
    pixel_t      fresh, above, below;
    coef_t       k;
    logic        tail, emit, border, closes;
    result_rec_t rec;
    cols = frame_cols();
    rows = frame_rows();
    col = (feed_col < MAX_WIDTH) ? feed_col : 0;
    row = feed_row;
    tail = (row >= rows);
    fresh = '0;
    if (!tail) begin
      // drop a flush while the frame is still coming in
      if (flush) return;
      fresh = px;
    end
    items_taken++;

    // shift the window and rotate the line history
    above = line_older[col];
    below = line_newer[col];
    for (r = 0; r < TAPS; r++) begin
      taps[r][0] = taps[r][1];
      taps[r][1] = taps[r][2];
    end
    taps[0][2] = above;
    taps[1][2] = below;
    taps[2][2] = fresh;
    line_older[col] = below;
    line_newer[col] = fresh;

    emit = (row >= 1 && col >= 1) || row >= 2;
    col++;
    if (col >= cols) begin
      col = 0;
      if (row < 'hFFFF) row++;
    end
    feed_col = col;
    feed_row = row;
    if (!emit) return;

    // border pixels pass through, interior ones get the kernel sum
    ocol = emit_col;
    orow = emit_row;
    border = orow == 0 || orow + 1 >= rows || ocol == 0 || ocol + 1 >= cols;
    if (border) begin
      acc = taps[1][1];
    end else begin
      acc = 0;
      for (r = 0; r < TAPS; r++) begin
        for (c = 0; c < TAPS; c++) begin
          k = kernel_rows[r][c*COEF_BITS +: COEF_BITS];
          acc += int'(taps[r][c]) * int'(k);
        end
      end
    end

    closes = (orow + 1 >= rows) && (ocol + 1 >= cols);
    rec.value = result_t'(acc);
    rec.eof = closes;
    filtered_queue.push_back(rec);
    if (closes) begin
      emit_col = 0;
      emit_row = 0;
      feed_col = 0;
      feed_row = 0;
      frames_closed++;
    end else begin
      ocol++;
      if (ocol >= cols) begin
        ocol = 0;
        orow++;
      end
      emit_col = ocol;
      emit_row = orow;
    end
  endfunction

  function automatic pixel_t random_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return pixel_t'($urandom_range(255));
    endcase
  endfunction

  function automatic krow_t random_krow();
    case ($urandom_range(7))
      0: return 24'h808080;
      1: return 24'h7F7F7F;
      2: return '0;
      default: return krow_t'($urandom);
    endcase
  endfunction

  // Send one input beat after a random gap; hold it until accepted
  task automatic send_item(pixel_t px, logic flush);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_value <= px;
    mode <= flush;
    do begin
      @(posedge clk);
    end while (in_stall);
    convolve_beat(px, flush);
  endtask

  // Drop valid and wait until every predicted pixel has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (filtered_queue.size() != 0) @(posedge clk);
    // let beats that release nothing clear the pipeline
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, cfg_data_t value);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_FRAME_WIDTH:  width_reg = value[WIDTH_BITS-1:0];
      REG_FRAME_HEIGHT: height_reg = value[ROW_BITS-1:0];
      REG_KERNEL_TOP:   kernel_rows[0] = value;
      REG_KERNEL_MID:   kernel_rows[1] = value;
      REG_KERNEL_BOT:   kernel_rows[2] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic set_config(int cols, int rows, krow_t top, krow_t mid, krow_t bot);
    write_reg(REG_FRAME_WIDTH, cfg_data_t'(cols));
    write_reg(REG_FRAME_HEIGHT, cfg_data_t'(rows));
    write_reg(REG_KERNEL_TOP, top);
    write_reg(REG_KERNEL_MID, mid);
    write_reg(REG_KERNEL_BOT, bot);
  endtask

  // Feed beats until the frame's last pixel is predicted; optionally
  // reconfigure at the start of row change_row (width may only shrink)
  task automatic run_frame(int flush_pct, int change_row);
    int closed_at;
    closed_at = frames_closed;
    while (frames_closed == closed_at) begin
      if (change_row >= 0 && feed_row == change_row && feed_col == 0) begin
        drain();
        set_config($urandom_range(1, frame_cols()), $urandom_range(1, frame_rows() + 3),
                   random_krow(), random_krow(), random_krow());
        change_row = -1;
      end
      if (feed_row >= frame_rows()) begin
        send_item(random_pixel(), 1'($urandom_range(1)));
      end else begin
        send_item(random_pixel(), $urandom_range(99) < flush_pct);
      end
    end
  endtask

  // Identity kernel from reset: only the frame size is changed
  task automatic test_reset_defaults();
    write_reg(REG_FRAME_WIDTH, cfg_data_t'(4));
    write_reg(REG_FRAME_HEIGHT, cfg_data_t'(3));
    run_frame(0, -1);
  endtask

  // Most negative and near-most positive sums, flushes inside and after the frame
  task automatic test_kernel_extremes();
    int i;
    drain();
    set_config(3, 3, 24'h808080, 24'h808080, 24'h808080);
    send_item(8'hFF, 1'b1);
    repeat (4) send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    repeat (5) send_item(8'hFF, 1'b0);
    // a pixel beat after the frame is in only pushes the tail
    send_item(8'hA5, 1'b0);
    run_frame(0, -1);
    drain();
    set_config(3, 3, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    for (i = 0; i < 9; i++) send_item((i == 0) ? 8'h00 : 8'hFF, 1'b0);
    send_item(8'h5A, 1'b1);
    run_frame(0, -1);
  endtask

  // Smallest frame, a tall narrow frame, masked register data
  task automatic test_size_extremes();
    drain();
    set_config(0, 0, random_krow(), random_krow(), random_krow());
    run_frame(10, -1);
    drain();
    set_config(1, 60, random_krow(), random_krow(), random_krow());
    run_frame(0, -1);
    drain();
    write_reg(REG_FRAME_WIDTH, 24'hFFF805);
    write_reg(REG_FRAME_HEIGHT, 24'h5A6003);
    run_frame(10, -1);
  endtask

  task automatic test_mid_frame_change();
    drain();
    set_config(6, 6, random_krow(), random_krow(), random_krow());
    run_frame(10, 2);
    drain();
    set_config(7, 5, random_krow(), random_krow(), random_krow());
    run_frame(10, 3);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int budget);
    int start, cols, rows;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    start = items_taken;
    while (items_taken - start < budget) begin
      // mostly a fresh setting per frame, sometimes frames back to back
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0: cols = $urandom_range(9, 48);
          1: cols = $urandom_range(0, 2);
          default: cols = $urandom_range(1, 8);
        endcase
        rows = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 7);
        drain();
        set_config(cols, rows, random_krow(), random_krow(), random_krow());
      end
      run_frame(10, (frame_rows() >= 3 && $urandom_range(4) == 0) ? 2 : -1);
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    pixel_value = '0;
    mode = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;

    // predictor matches the block after reset
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    kernel_rows[0] = KTOP_RESET;
    kernel_rows[1] = KMID_RESET;
    kernel_rows[2] = KBOT_RESET;
    for (i = 0; i < MAX_WIDTH; i++) begin
      line_older[i] = '0;
      line_newer[i] = '0;
    end
    for (i = 0; i < TAPS * TAPS; i++) taps[i / TAPS][i % TAPS] = '0;
    feed_col = 0;
    feed_row = 0;
    emit_col = 0;
    emit_row = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_kernel_extremes();
    test_size_extremes();
    test_mid_frame_change();
    test_random_traffic(0, 0, 100);
    test_random_traffic(78, 0, 100);
    test_random_traffic(0, 78, 100);
    test_random_traffic(36, 36, 100);

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    drain();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
rtl/core/ic3_pkg.sv
rtl/core/image_convolution_3x3_core.sv
tb/tb_top.sv
